// ===== sv/nwrd_pkg.sv =====
// Shared types and constants of the nonwear run detector.
package nwrd_pkg;

  // Saturating epoch index and run length width
  localparam int unsigned IdxBits    = 24;
  localparam int unsigned CountBits  = 16;
  localparam int unsigned WinBits    = 12;
  localparam int unsigned TolBits    = 8;
  localparam int unsigned CfgIdxBits = 2;
  localparam int unsigned CfgBits    = 16;
  localparam int unsigned OutBits    = 56;

  // Result queue geometry
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrBits = 2;
  localparam int unsigned QCntBits = 3;

  localparam logic [IdxBits-1:0] IdxMax = {IdxBits{1'b1}};

  // Configuration register indexes
  typedef enum logic [CfgIdxBits-1:0] {
    CFG_WINDOW    = 2'd0,
    CFG_TOLERANCE = 2'd1,
    CFG_CEILING   = 2'd2,
    CFG_NEIGHBOUR = 2'd3
  } cfg_reg_e;

  // One closed run as it travels to the output
  typedef struct packed {
    logic               last;
    logic               nonwear;
    logic [IdxBits-1:0] run_length;
    logic [IdxBits-1:0] run_start;
  } res_t;

  // Pushes from the run logic into the result queue
  typedef struct packed {
    logic push0;
    logic push1;
  } qpush_t;

endpackage

// ===== sv/nwrd_out_fifo.sv =====
// Result queue: takes up to two results a cycle, hands out one per transfer.
module nwrd_out_fifo
  import nwrd_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  qpush_t push_i,
  input  res_t   res0_i,
  input  res_t   res1_i,
  output logic   room_o,
  output logic   valid_o,
  input  logic   ready_i,
  output res_t   head_o
);

  res_t                mem_q [QDepth];
  logic [QPtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntBits-1:0] cnt_q, cnt_d;
  logic                pop;
  logic [QPtrBits-1:0] wr_ptr_nx;

  assign pop       = valid_o && ready_i;
  assign valid_o   = (cnt_q != '0);
  assign room_o    = (cnt_q <= QCntBits'(QDepth - 2));
  assign head_o    = mem_q[rd_ptr_q];
  assign wr_ptr_nx = wr_ptr_q + QPtrBits'(1);

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q + QPtrBits'(push_i.push0) + QPtrBits'(push_i.push1);
    rd_ptr_d = rd_ptr_q + QPtrBits'(pop);
    cnt_d    = cnt_q + QCntBits'(push_i.push0) + QCntBits'(push_i.push1)
               - QCntBits'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store results in order
  always_ff @(posedge clk_i) begin
    if (push_i.push0) begin
      mem_q[wr_ptr_q] <= res0_i;
    end
    if (push_i.push1) begin
      mem_q[wr_ptr_nx] <= res1_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntBits'(QDepth))
    else $error("result queue overfilled");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.push0 || push_i.push1) |-> room_o)
    else $error("push into queue without room");

  a_push_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.push1 |-> push_i.push0)
    else $error("second result pushed without first");

endmodule

// ===== sv/nonwear_run_detector.sv =====
// Top level: groups epoch counts into quiet runs and reports each closed run.
//
// Channel   Direction  Contents
// s_axis    in         tdata[15:0] count, tlast final_epoch
// m_axis    out        tdata[23:0] run_start, [47:24] run_length, [48] nonwear;
//                      tlast last_of_item
// cfg       in         write enable, register index, data (no read-back)
//
// One epoch is taken per cycle while s_axis_tready is high; the run counters
// update in the cycle of the transfer and closed runs enter a four-entry result queue.
// An epoch that closes two runs puts two results in the queue; s_axis_tready
// stays high while at least two queue slots are free.
// Results leave one per m_axis transfer; a stall on m_axis fills the queue and
// then holds s_axis_tready low.
// Reset clears counters, queue and registers to their defaults at once.
module nonwear_run_detector
  import nwrd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [CountBits-1:0]  s_axis_tdata,   // count
  input  logic                  s_axis_tlast,   // final_epoch
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OutBits-1:0]    m_axis_tdata,   // run_start, run_length, nonwear, pad
  output logic                  m_axis_tlast,   // last_of_item
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_idx_i,
  input  logic [CfgBits-1:0]    cfg_data_i
);

  // Configuration registers
  logic [WinBits-1:0]   window_q;
  logic [TolBits-1:0]   tol_q;
  logic [CountBits-1:0] ceil_q;
  logic                 nbr_q;

  // Run state
  logic [IdxBits-1:0] epoch_q, epoch_d;
  logic [IdxBits-1:0] start_q, start_d;
  logic [IdxBits-1:0] len_q, len_d;
  logic [TolBits-1:0] spike_q, spike_d;

  logic   accept;
  qpush_t push;
  res_t   res0, res1, head;

  assign accept = s_axis_tvalid && s_axis_tready;

  // Nonwear verdict for a run of the given length
  function automatic logic verdict(input logic [IdxBits-1:0] len,
                                   input logic spike_end,
                                   input logic [WinBits-1:0] win,
                                   input logic [TolBits-1:0] tol,
                                   input logic nbr);
    logic signed [IdxBits+1:0] have;
    logic signed [IdxBits+1:0] need;
    have = $signed({2'b00, len}) - $signed((IdxBits+2)'(spike_end));
    need = $signed((IdxBits+2)'(win)) - $signed((IdxBits+2)'(tol));
    return (have >= need) && !(nbr && spike_end);
  endfunction

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WinBits'(60);
      tol_q    <= TolBits'(2);
      ceil_q   <= CountBits'(100);
      nbr_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_WINDOW:    window_q <= cfg_data_i[WinBits-1:0];
        CFG_TOLERANCE: tol_q    <= cfg_data_i[TolBits-1:0];
        CFG_CEILING:   ceil_q   <= cfg_data_i;
        CFG_NEIGHBOUR: nbr_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Classify the epoch, extend or close the open run
  always_comb begin
    logic               low;
    logic [TolBits:0]   spike_inc;
    logic               take;
    logic               close_a;
    logic               close_b;
    logic [IdxBits-1:0] len_a;
    logic [IdxBits-1:0] start_a;
    res_t               ra, rb;

    epoch_d   = epoch_q;
    start_d   = start_q;
    len_d     = len_q;
    spike_d   = spike_q;
    low       = (s_axis_tdata <= ceil_q);
    spike_inc = {1'b0, spike_q} + (TolBits+1)'(1);
    take      = 1'b0;
    close_a   = 1'b0;
    close_b   = 1'b0;
    ra        = '0;
    rb        = '0;
    len_a     = len_q;
    start_a   = start_q;

    if (low) begin
      if (s_axis_tdata != '0) begin
        if (spike_inc > {1'b0, tol_q}) begin
          // spike too long: close without it, maybe restart on it
          close_a = (len_q != '0);
          ra      = '{last: 1'b0,
                      nonwear: verdict(len_q, 1'b0, window_q, tol_q, nbr_q),
                      run_length: len_q, run_start: start_q};
          len_a   = close_a ? '0 : len_q;
          take    = (tol_q != '0);
          spike_d = (tol_q != '0) ? TolBits'(1) : '0;
        end else begin
          spike_d = spike_inc[TolBits-1:0];
          take    = 1'b1;
        end
      end else begin
        spike_d = '0;
        take    = 1'b1;
      end
      if (take) begin
        if (len_a == '0) begin
          start_a = epoch_q;
          len_a   = IdxBits'(1);
        end else if (len_a != IdxMax) begin
          len_a = len_a + IdxBits'(1);
        end
      end
      // final epoch closes whatever is open
      if (s_axis_tlast && (len_a != '0)) begin
        close_b = 1'b1;
        rb      = '{last: 1'b1,
                    nonwear: verdict(len_a, 1'b0, window_q, tol_q, nbr_q),
                    run_length: len_a, run_start: start_a};
        len_a   = '0;
        spike_d = '0;
      end
    end else begin
      // high count closes the open run
      close_a = (len_q != '0);
      ra      = '{last: 1'b0,
                  nonwear: verdict(len_q, spike_q != '0, window_q, tol_q, nbr_q),
                  run_length: len_q, run_start: start_q};
      len_a   = '0;
      spike_d = '0;
    end

    // Order the results: the earlier one goes first
    push.push0 = 1'b0;
    push.push1 = 1'b0;
    res0       = ra;
    res1       = rb;
    if (accept) begin
      epoch_d = (epoch_q != IdxMax) ? epoch_q + IdxBits'(1) : epoch_q;
      start_d = start_a;
      len_d   = len_a;
      if (close_a) begin
        push.push0 = 1'b1;
        push.push1 = close_b;
        res0.last  = !close_b;
      end else begin
        push.push0 = close_b;
        res0       = rb;
      end
    end else begin
      spike_d = spike_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_q <= '0;
      start_q <= '0;
      len_q   <= '0;
      spike_q <= '0;
    end else begin
      epoch_q <= epoch_d;
      start_q <= start_d;
      len_q   <= len_d;
      spike_q <= spike_d;
    end
  end

  nwrd_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .res0_i  (res0),
    .res1_i  (res1),
    .room_o  (s_axis_tready),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .head_o  (head)
  );

  // Pack the queue head onto the output bus
  assign m_axis_tdata = {(OutBits - 2*IdxBits - 1)'(0), head.nonwear,
                         head.run_length, head.run_start};
  assign m_axis_tlast = head.last;

  a_spike_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q == '0) |-> (spike_q == '0))
    else $error("spike length held with no open run");

  a_final_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tlast) |=> (len_q == '0))
    else $error("final epoch left a run open");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("result changed while stalled");

endmodule

// ===== test/nonwear_run_detector_test.sv =====
// Self-checking testbench of the nonwear run detector with an in-bench run predictor.
module nonwear_run_detector_test
  import nwrd_pkg::*;
();

  localparam int unsigned LimitCycles  = 400000;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned PhaseEpochs  = 200;
  localparam int unsigned NumPhases    = 8;

  // Run predictor and store of runs still due on the master side
  class nonwear_board;
    logic [WinBits-1:0]   win_len;
    logic [TolBits-1:0]   tol;
    logic [CountBits-1:0] ceiling;
    logic                 nbr_chk;
    logic [IdxBits-1:0]   epoch_idx;
    logic [IdxBits-1:0]   run_start;
    logic [IdxBits-1:0]   run_len;
    int                   spike_len;
    res_t                 pending[$];
    int                   errors;
    int                   epochs;
    int                   runs;
    int                   nonwear_runs;
    int                   double_closes;

    function new();
      win_len       = 12'd60;
      tol           = 8'd2;
      ceiling       = 16'd100;
      nbr_chk       = 1'b0;
      epoch_idx     = '0;
      run_start     = '0;
      run_len       = '0;
      spike_len     = 0;
      errors        = 0;
      epochs        = 0;
      runs          = 0;
      nonwear_runs  = 0;
      double_closes = 0;
    endfunction

    function void write_reg(cfg_reg_e r, logic [CfgBits-1:0] v);
      case (r)
        CFG_WINDOW:    win_len = v[WinBits-1:0];
        CFG_TOLERANCE: tol     = v[TolBits-1:0];
        CFG_CEILING:   ceiling = v[CountBits-1:0];
        CFG_NEIGHBOUR: nbr_chk = v[0];
        default: ;
      endcase
    endfunction

    function logic [IdxBits-1:0] bump(logic [IdxBits-1:0] v);
      return (v == IdxMax) ? v : v + 1'b1;
    endfunction

    // Close the open run; a spike-ended run gives up one epoch of credit
    function void close_run(bit spike_end);
      res_t r;
      int   have;
      int   need;
      have         = int'(run_len) - (spike_end ? 1 : 0);
      need         = int'(win_len) - int'(tol);
      r.run_start  = run_start;
      r.run_length = run_len;
      r.nonwear    = (have >= need) && !(nbr_chk && spike_end);
      r.last       = 1'b0;
      pending      = {pending, r};
      run_len = '0;
    endfunction

    function void take(logic [IdxBits-1:0] idx);
      if (run_len == '0) begin
        run_start = idx;
        run_len   = IdxBits'(1);
      end else begin
        run_len = bump(run_len);
      end
    endfunction

    function void note_epoch(logic [CountBits-1:0] c, logic fin);
      logic [IdxBits-1:0] idx;
      int                 queued;
      idx       = epoch_idx;
      queued    = pending.size();
      epoch_idx = bump(epoch_idx);
      epochs++;
      if (c <= ceiling) begin
        if (c != '0) begin
          // spike that outgrows the tolerance starts afresh
          if (spike_len + 1 > int'(tol)) begin
            if (run_len != '0) close_run(1'b0);
            spike_len = 0;
            if (tol >= 1) begin
              take(idx);
              spike_len = 1;
            end
          end else begin
            spike_len++;
            take(idx);
          end
        end else begin
          spike_len = 0;
          take(idx);
        end
        if (fin && run_len != '0) begin
          close_run(1'b0);
          spike_len = 0;
        end
      end else begin
        if (run_len != '0) close_run(spike_len > 0);
        spike_len = 0;
      end
      if (pending.size() - queued == 2) double_closes++;
      if (pending.size() > queued) pending[pending.size()-1].last = 1'b1;
    endfunction

    function void check_run(logic [OutBits-1:0] d, logic l);
      res_t want;
      if (pending.size() == 0) begin
        $error("unexpected run: start %0d length %0d", d[IdxBits-1:0],
               d[2*IdxBits-1:IdxBits]);
        errors++;
        return;
      end
      want = pending.pop_front();
      runs++;
      if (want.nonwear) nonwear_runs++;
      if (d[IdxBits-1:0] !== want.run_start) begin
        $error("run_start: expected %0d, got %0d", want.run_start, d[IdxBits-1:0]);
        errors++;
      end
      if (d[2*IdxBits-1:IdxBits] !== want.run_length) begin
        $error("run_length: expected %0d, got %0d", want.run_length,
               d[2*IdxBits-1:IdxBits]);
        errors++;
      end
      if (d[2*IdxBits] !== want.nonwear) begin
        $error("nonwear: expected %0b, got %0b", want.nonwear, d[2*IdxBits]);
        errors++;
      end
      if (l !== want.last) begin
        $error("last_of_item: expected %0b, got %0b", want.last, l);
        errors++;
      end
      if (d[OutBits-1:2*IdxBits+1] !== '0) begin
        $error("tdata padding: expected 0, got %0h", d[OutBits-1:2*IdxBits+1]);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [CountBits-1:0]  s_axis_tdata = '0;   // count
  logic                  s_axis_tlast = 1'b0; // final_epoch
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OutBits-1:0]    m_axis_tdata;        // run_start, run_length, nonwear, pad
  logic                  m_axis_tlast;        // last_of_item
  logic                  cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0] cfg_idx_i = '0;
  logic [CfgBits-1:0]    cfg_data_i = '0;

  nonwear_run_detector uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  nonwear_board board = new();
  int unsigned  cycle_cnt = 0;
  int unsigned  gap_pct = 0;
  int unsigned  stall_pct = 0;
  int unsigned  stim_sent = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Note accepted epochs before checking results of the same edge
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (rst_ni && s_axis_tvalid && s_axis_tready) board.note_epoch(s_axis_tdata, s_axis_tlast);
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_run(m_axis_tdata, m_axis_tlast);
    if (cycle_cnt >= LimitCycles) begin
      $display("timeout after %0d cycles, %0d runs outstanding", cycle_cnt,
               board.pending.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Stall the result side at random
  always @(negedge clk_i) begin
    m_axis_tready = ($urandom_range(99, 0) >= stall_pct);
  end

  task automatic set_idling(int unsigned mode);
    case (mode % 4)
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 46; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 46; end
      default: begin gap_pct = 38; stall_pct = 38; end
    endcase
  endtask

  // Offer one epoch, with random gaps ahead of it, and hold it until transferred
  task automatic send_epoch(logic [CountBits-1:0] c, logic fin);
    @(negedge clk_i);
    while ($urandom_range(99, 0) < gap_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = c;
    s_axis_tlast  = fin;
    do @(posedge clk_i); while (!s_axis_tready);
    stim_sent++;
  endtask

  // Drop valid and let every due run drain out
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_reg_e r, logic [CfgBits-1:0] v);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = r;
    cfg_data_i = v;
    board.write_reg(r, v);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic apply_config(int unsigned w, int unsigned t, int unsigned c, int unsigned n);
    cfg_write(CFG_WINDOW, CfgBits'(w));
    cfg_write(CFG_TOLERANCE, CfgBits'(t));
    cfg_write(CFG_CEILING, CfgBits'(c));
    cfg_write(CFG_NEIGHBOUR, CfgBits'(n));
  endtask

  function automatic logic [CountBits-1:0] low_count();
    if (board.ceiling == '0) return '0;
    return CountBits'($urandom_range(int'(board.ceiling), 1));
  endfunction

  function automatic logic [CountBits-1:0] high_count();
    if (board.ceiling == {CountBits{1'b1}}) return board.ceiling;
    return CountBits'($urandom_range(65535, int'(board.ceiling) + 1));
  endfunction

  // Quiet run with random spikes, closed by a high count or the final epoch
  task automatic quiet_run();
    int cap;
    int body;
    int k;
    int sp;
    int tcap;
    tcap = (board.tol > 6) ? 6 : int'(board.tol);
    cap  = (int'(board.win_len) + 2 > 48) ? 48 : int'(board.win_len) + 2;
    body = $urandom_range(cap, 1);
    k    = 0;
    while (k < body) begin
      if ($urandom_range(5, 0) == 0) begin
        sp = $urandom_range(tcap + 1, 1);
        repeat (sp) send_epoch(low_count(), 1'b0);
        k += sp;
      end else begin
        send_epoch('0, 1'b0);
        k++;
      end
    end
    case ($urandom_range(3, 0))
      0: send_epoch(high_count(), 1'($urandom_range(1, 0)));
      1: begin
        repeat ($urandom_range(tcap > 0 ? tcap : 1, 1)) send_epoch(low_count(), 1'b0);
        send_epoch(high_count(), 1'b0);
      end
      2: send_epoch('0, 1'b1);
      default: send_epoch(low_count(), 1'b1);
    endcase
  endtask

  task automatic noise_burst();
    logic [CountBits-1:0] c;
    repeat ($urandom_range(4, 1)) begin
      case ($urandom_range(2, 0))
        0: c = '0;
        1: c = low_count();
        default: c = CountBits'($urandom);
      endcase
      send_epoch(c, 1'($urandom_range(15, 0) == 0));
    end
  endtask

  initial begin
    int unsigned w;
    int unsigned t;
    int unsigned c;
    int unsigned n;
    int unsigned phase_end;

    set_idling(0);
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: short quiet run closed by the largest count
    send_epoch('0, 1'b0);
    send_epoch('0, 1'b0);
    send_epoch('0, 1'b0);
    send_epoch(16'hFFFF, 1'b0);
    wait_idle();

    apply_config(4, 2, 100, 0);
    // Spike at the ceiling then a high count: spike-ended nonwear run
    repeat (4) send_epoch('0, 1'b0);
    send_epoch(16'd100, 1'b0);
    send_epoch(16'd101, 1'b0);
    // Spike grows too long on the final epoch: two runs from one item
    send_epoch('0, 1'b0);
    send_epoch(16'd1, 1'b0);
    send_epoch(16'd1, 1'b0);
    send_epoch(16'd1, 1'b1);
    // High counts with nothing open, and a single final zero
    send_epoch(16'hFFFF, 1'b0);
    send_epoch('0, 1'b1);
    send_epoch(16'hFFFF, 1'b1);
    wait_idle();

    // Neighbour check rejects a spike-ended run but keeps a clean one
    cfg_write(CFG_NEIGHBOUR, 16'd1);
    repeat (3) send_epoch('0, 1'b0);
    send_epoch(16'd5, 1'b0);
    send_epoch(16'd200, 1'b0);
    repeat (3) send_epoch('0, 1'b0);
    send_epoch(16'd300, 1'b0);
    wait_idle();

    // No spike allowance: a spike closes the run and opens nothing
    cfg_write(CFG_TOLERANCE, 16'd0);
    send_epoch('0, 1'b0);
    send_epoch('0, 1'b0);
    send_epoch(16'd7, 1'b0);
    send_epoch('0, 1'b1);
    wait_idle();

    // Random phases under changing settings and idling
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin w = 1;    t = 0;   c = 0;     n = 0; end
        1: begin w = 4095; t = 255; c = 65535; n = 1; end
        2: begin w = 1;    t = 5;   c = 40;    n = 1; end
        default: begin
          w = $urandom_range(30, 1);
          t = $urandom_range(6, 0);
          c = ($urandom_range(1, 0) != 0) ? $urandom_range(65535, 0) : $urandom_range(300, 1);
          n = $urandom_range(1, 0);
        end
      endcase
      apply_config(w, t, c, n);
      set_idling(p);
      phase_end = stim_sent + PhaseEpochs;
      while (stim_sent < phase_end) begin
        if ($urandom_range(4, 0) != 0) quiet_run();
        else noise_burst();
      end
      wait_idle();
      set_idling(0);
    end

    $display("covered %0d epochs over %0d random settings and four idling patterns",
             board.epochs, NumPhases);
    $display("checked %0d runs, %0d nonwear, %0d epochs closing two runs",
             board.runs, board.nonwear_runs, board.double_closes);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d runs never seen", board.errors, board.pending.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/nwrd_pkg.sv
sv/nwrd_out_fifo.sv
sv/nonwear_run_detector.sv
test/nonwear_run_detector_test.sv
